/* rtl/bitfield_stream_packer_top_defines.svh */
// assertion macros used by the packer rtl
`ifndef BITFIELD_STREAM_PACKER_TOP_DEFINES_SVH
`define BITFIELD_STREAM_PACKER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define BSP_ASSERT_AR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsp assertion failed");

// consequent checked in the cycle after the antecedent
`define BSP_ASSERT_NEXT(lbl, ante, cons) \
  `BSP_ASSERT_AR(lbl, (ante) |=> (cons))

`endif

/* rtl/bsp_pkg.sv */
// shared constants and types of the bit field packer
package bsp_pkg;

  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STORE_BITS  = STORE_WORDS * WORD_W;
  localparam int unsigned ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned CNT_W       = 16;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_POKE   = 3'd1,
    CMD_TRUNC  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_REFUSED  = 2'd2
  } status_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  bit_count;
    logic [WORD_W-1:0] read_data;
    logic              error_sticky;
  } res_t;

endpackage

/* rtl/bsp_store.sv */
// single port word store, registered read data
module bsp_store
  import bsp_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_o <= mem[req_i.addr];
      end
    end
  end

endmodule

/* rtl/bsp_ctrl.sv */
// request decode, bit count state and read-modify-write sequencer
`include "bitfield_stream_packer_top_defines.svh"

module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wen_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [31:0]       field_value_i,
  input  logic [5:0]        field_length_i,
  input  logic [15:0]       bit_position_i,
  input  logic [9:0]        word_index_i,
  output mem_req_t          mem_req_o,
  input  logic [WORD_W-1:0] mem_rdata_i,
  output logic              res_valid_o,
  output res_t              res_o,
  input  logic              res_ready_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MRG0 = 6'b000010,
    S_RD1  = 6'b000100,
    S_MRG1 = 6'b001000,
    S_RDW  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] wb_q, wb_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] cap_q;

  logic [10:0]      idx_q;
  logic [63:0]      mask_q;
  logic [63:0]      data_q;
  res_t             res_q;

  logic             acc;
  logic [5:0]       len_sat;
  logic [16:0]      usable;
  logic [16:0]      app_end;
  logic [16:0]      poke_end;
  status_e          acc_status;
  logic             do_wr;
  logic             do_rd;
  logic [15:0]      wr_pos;
  logic [63:0]      acc_ones;
  logic [63:0]      acc_mask;
  logic [63:0]      acc_data;
  res_t             acc_res;

  logic [11:0]      idx1;
  logic             idx0_ok;
  logic             idx1_ok;
  logic             fin;
  res_t             fin_res;

  assign acc        = (state_q == S_IDLE) && in_valid_i;
  assign in_ready_o = (state_q == S_IDLE);

  // request decode against the current count
  always_comb begin
    len_sat    = (field_length_i > 6'd32) ? 6'd32 : field_length_i;
    usable     = (32'(cap_q) > STORE_BITS) ? 17'(STORE_BITS) : {1'b0, cap_q};
    app_end    = {1'b0, wb_q} + 17'(len_sat);
    poke_end   = {1'b0, bit_position_i} + 17'(len_sat);
    acc_status = ST_OK;
    wb_d       = wb_q;
    ovf_d      = ovf_q;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    wr_pos     = wb_q;
    case (cmd_e'(cmd_i))
      CMD_APPEND: begin
        if (app_end > usable) begin
          acc_status = ST_OVERFLOW;
          ovf_d      = 1'b1;
        end else begin
          wb_d  = app_end[CNT_W-1:0];
          do_wr = (len_sat != 6'd0);
        end
      end
      CMD_POKE: begin
        wr_pos = bit_position_i;
        if ((poke_end > {1'b0, wb_q}) || (poke_end > usable)) begin
          acc_status = ST_OVERFLOW;
          ovf_d      = 1'b1;
        end else begin
          do_wr = (len_sat != 6'd0);
        end
      end
      CMD_TRUNC: begin
        if (bit_position_i > wb_q) begin
          acc_status = ST_REFUSED;
        end else begin
          wb_d = bit_position_i;
        end
      end
      CMD_READ: begin
        do_rd = (32'(word_index_i) < STORE_WORDS);
      end
      CMD_CLEAR: begin
        ovf_d = 1'b0;
      end
      default: begin
      end
    endcase
    acc_ones = (64'd1 << len_sat) - 64'd1;
    acc_mask = acc_ones << wr_pos[4:0];
    acc_data = (64'(field_value_i) << wr_pos[4:0]) & acc_mask;
    acc_res  = '{status: acc_status, bit_count: wb_d, read_data: '0, error_sticky: ovf_d};
  end

  assign idx1    = 12'(idx_q) + 12'd1;
  assign idx0_ok = (32'(idx_q) < STORE_WORDS);
  assign idx1_ok = (32'(idx1) < STORE_WORDS);

  // sequencer: read word, merge and write back, then the spill word; or a word read, or a direct result
  always_comb begin
    state_d   = state_q;
    fin       = 1'b0;
    fin_res   = res_q;
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (do_wr) begin
            mem_req_o.en   = (32'(wr_pos[15:5]) < STORE_WORDS);
            mem_req_o.addr = ADDR_W'(32'(wr_pos[15:5]));
            state_d        = S_MRG0;
          end else if (do_rd) begin
            mem_req_o.en   = 1'b1;
            mem_req_o.addr = ADDR_W'(32'(word_index_i));
            state_d        = S_RDW;
          end else begin
            fin     = 1'b1;
            fin_res = acc_res;
            state_d = res_ready_i ? S_IDLE : S_DONE;
          end
        end
      end
      S_MRG0: begin
        mem_req_o.en    = idx0_ok;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = ADDR_W'(32'(idx_q));
        mem_req_o.wdata = (mem_rdata_i & ~mask_q[31:0]) | data_q[31:0];
        if (|mask_q[63:32]) begin
          state_d = S_RD1;
        end else begin
          fin     = 1'b1;
          state_d = res_ready_i ? S_IDLE : S_DONE;
        end
      end
      S_RD1: begin
        mem_req_o.en   = idx1_ok;
        mem_req_o.addr = ADDR_W'(32'(idx1));
        state_d        = S_MRG1;
      end
      S_MRG1: begin
        mem_req_o.en    = idx1_ok;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = ADDR_W'(32'(idx1));
        mem_req_o.wdata = (mem_rdata_i & ~mask_q[63:32]) | data_q[63:32];
        fin             = 1'b1;
        state_d         = res_ready_i ? S_IDLE : S_DONE;
      end
      S_RDW: begin
        fin               = 1'b1;
        fin_res.read_data = mem_rdata_i;
        state_d           = res_ready_i ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        fin     = 1'b1;
        state_d = res_ready_i ? S_IDLE : S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_valid_o = fin;
  assign res_o       = fin_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wb_q    <= '0;
      ovf_q   <= 1'b0;
      cap_q   <= CNT_W'(32768);
    end else begin
      state_q <= state_d;
      if (acc) begin
        wb_q  <= wb_d;
        ovf_q <= ovf_d;
      end
      if (cfg_wen_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      idx_q  <= wr_pos[15:5];
      mask_q <= acc_mask;
      data_q <= acc_data;
      res_q  <= acc_res;
    end else if (fin && !res_ready_i) begin
      res_q <= fin_res;
    end
  end

  `BSP_ASSERT_AR(a_state_onehot, $onehot(state_q))
  `BSP_ASSERT_AR(a_write_in_merge,
                 (mem_req_o.en && mem_req_o.we) |-> (state_q == S_MRG0 || state_q == S_MRG1))
  `BSP_ASSERT_NEXT(a_count_holds, !acc, wb_q == $past(wb_q))
  `BSP_ASSERT_NEXT(a_fin_to_idle, fin && res_ready_i, state_q == S_IDLE)
  `BSP_ASSERT_NEXT(a_stall_holds, fin && !res_ready_i, state_q == S_DONE)

endmodule

/* rtl/bsp_outreg.sv */
// result output register between sequencer and consumer
module bsp_outreg
  import bsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  res_t              res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  bit_count_o,
  output logic [WORD_W-1:0] read_data_o,
  output logic              error_sticky_o
);

  logic valid_q;
  res_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = data_q.status;
  assign bit_count_o    = data_q.bit_count;
  assign read_data_o    = data_q.read_data;
  assign error_sticky_o = data_q.error_sticky;

endmodule

/* rtl/bitfield_stream_packer_top.sv */
// top level of the lsb-first bit field packer with its word store
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_wen_i              cfg_wdata_i (capacity in bits)
//   in       in         in_valid_i/in_ready_o  cmd, field value/length, bit position, word index
//   out      out        out_valid_o/out_ready_i status, bit count, read data, sticky error
//
// one request at a time; truncate, clear, refused, overflowing and zero-length requests
// answer from idle; append or poke reads its word, merges and writes it back, then any spill
// word likewise; a word read returns the single port store's registered read data
// reset clears count, sticky error and sequencer; capacity resets to 32768 bits
// store contents are undefined until written; no clearing pass
// a finished result sits in the output register while the next request is taken;
// the sequencer waits only when a result meets a full register the consumer is not taking
module bitfield_stream_packer_top
  import bsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] field_value_i,
  input  logic [5:0]  field_length_i,
  input  logic [15:0] bit_position_i,
  input  logic [9:0]  word_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] bit_count_o,
  output logic [31:0] read_data_o,
  output logic        error_sticky_o
);

  // store access from the sequencer, registered read data back in the next cycle
  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  // finished result toward the output register
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // decode, count state and read-modify-write sequencing; the fsm only
  // takes a new request in idle, so a write back always lands before the
  // next request reads the same word
  bsp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wen_i      (cfg_wen_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .field_value_i  (field_value_i),
    .field_length_i (field_length_i),
    .bit_position_i (bit_position_i),
    .word_index_i   (word_index_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // word store, one access per cycle
  bsp_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register decouples the consumer's stalls from the sequencer
  bsp_outreg u_outreg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_i          (res),
    .res_ready_o    (res_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .bit_count_o    (bit_count_o),
    .read_data_o    (read_data_o),
    .error_sticky_o (error_sticky_o)
  );

endmodule

/* sim/bitfield_stream_packer_top_test.sv */
// self-checking testbench for the bit field packer top level
`timescale 1ns / 1ps

module bitfield_stream_packer_top_test;
  import bsp_pkg::*;

  // cycles without any request or result moving before the run is declared hung
  localparam int unsigned STALL_LIMIT = 3000;
  // length of the long receiver hold-off that backs up the packer
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] value;
    logic [5:0]  len;
    logic [15:0] pos;
    logic [9:0]  widx;
  } pack_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wen_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [31:0] field_value_i;
  logic [5:0]  field_length_i;
  logic [15:0] bit_position_i;
  logic [9:0]  word_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] bit_count_o;
  logic [31:0] read_data_o;
  logic        error_sticky_o;

  // shadow copy of the packer state
  bit [31:0]   shadow_words   [STORE_WORDS];
  bit [31:0]   shadow_written [STORE_WORDS];
  int unsigned shadow_count = 0;
  bit          shadow_sticky = 1'b0;
  int unsigned shadow_cap = 32768;
  // words whose every bit has been written, the only ones that may be read back
  int unsigned full_words[$];

  pack_req_t   pend_q[$];
  res_t        due_results[$];

  logic        req_fire = 1'b0;
  int unsigned send_gap_pct;
  int unsigned take_gap_pct;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt = 0;

  bitfield_stream_packer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .field_value_i (field_value_i),
    .field_length_i(field_length_i),
    .bit_position_i(bit_position_i),
    .word_index_i  (word_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .bit_count_o   (bit_count_o),
    .read_data_o   (read_data_o),
    .error_sticky_o(error_sticky_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // merge masked bits into one shadow word and note when it becomes fully written
  function automatic void merge_word(int unsigned idx, logic [31:0] mask, logic [31:0] data);
    bit was_full;
    if (mask == '0 || idx >= STORE_WORDS) return;
    was_full = &shadow_written[idx];
    shadow_words[idx] = (shadow_words[idx] & ~mask) | (data & mask);
    shadow_written[idx] |= mask;
    if (!was_full && &shadow_written[idx]) full_words.push_back(idx);
  endfunction

  // lsb-first field write, spilling into the next word at a boundary
  function automatic void put_field(int unsigned pos, logic [31:0] val, int unsigned len);
    logic [63:0] mask;
    logic [63:0] data;
    if (len == 0) return;
    mask = ((64'd1 << len) - 64'd1) << (pos & 31);
    data = ({32'd0, val} << (pos & 31)) & mask;
    merge_word(pos >> 5, mask[31:0], data[31:0]);
    merge_word((pos >> 5) + 1, mask[63:32], data[63:32]);
  endfunction

  // applies one request to the shadow state and returns the result it must produce
  function automatic res_t apply_request(pack_req_t r);
    res_t        res;
    int unsigned len;
    int unsigned lim;
    res = '0;
    res.status = ST_OK;
    len = (r.len > 32) ? 32 : r.len;
    lim = (shadow_cap < STORE_BITS) ? shadow_cap : STORE_BITS;
    case (r.cmd)
      CMD_APPEND: begin
        if (shadow_count + len > lim) begin
          res.status = ST_OVERFLOW;
          shadow_sticky = 1'b1;
        end else begin
          put_field(shadow_count, r.value, len);
          shadow_count = (shadow_count + len) & 32'hFFFF;
        end
      end
      CMD_POKE: begin
        // only inside the written range, and never past the capacity
        if (r.pos + len > shadow_count || r.pos + len > lim) begin
          res.status = ST_OVERFLOW;
          shadow_sticky = 1'b1;
        end else begin
          put_field(r.pos, r.value, len);
        end
      end
      CMD_TRUNC: begin
        // raising the count is refused without touching the sticky flag
        if (r.pos > shadow_count) res.status = ST_REFUSED;
        else shadow_count = r.pos;
      end
      CMD_READ: begin
        if (r.widx < STORE_WORDS) res.read_data = shadow_words[r.widx];
      end
      CMD_CLEAR: begin
        shadow_sticky = 1'b0;
      end
      default: ;
    endcase
    res.bit_count = 16'(shadow_count);
    res.error_sticky = shadow_sticky;
    return res;
  endfunction

  // request driver: new payload at the falling edge, held until taken
  always @(negedge clk_i) begin : req_driver
    pack_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_fire) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt = pend_q.pop_front();
        cmd_i          <= nxt.cmd;
        field_value_i  <= nxt.value;
        field_length_i <= nxt.len;
        bit_position_i <= nxt.pos;
        word_index_i   <= nxt.widx;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin : result_sink
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  // monitor: predicts on each taken request, checks each delivered result
  always @(posedge clk_i) begin : packer_monitor
    pack_req_t taken;
    res_t      want;
    logic      in_fire;
    logic      out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    req_fire <= in_fire;
    if (out_fire) begin
      if (due_results.size() == 0) begin
        if (err_cnt < 10)
          $display("%0t: unexpected result status %0d count %0d data %h sticky %0d",
                   $realtime, status_o, bit_count_o, read_data_o, error_sticky_o);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (want.status !== status_o || want.bit_count !== bit_count_o ||
            want.read_data !== read_data_o || want.error_sticky !== error_sticky_o) begin
          if (err_cnt < 10)
            $display("%0t: mismatch exp st %0d cnt %0d data %h err %0d, got %0d %0d %h %0d",
                     $realtime, want.status, want.bit_count, want.read_data,
                     want.error_sticky, status_o, bit_count_o, read_data_o, error_sticky_o);
          err_cnt++;
        end
      end
    end
    if (in_fire) begin
      taken.cmd   = cmd_e'(cmd_i);
      taken.value = field_value_i;
      taken.len   = field_length_i;
      taken.pos   = bit_position_i;
      taken.widx  = word_index_i;
      due_results.push_back(apply_request(taken));
    end
    stall_cycles <= (in_fire || out_fire) ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("** bitfield_stream_packer_top: FAILED **");
    $finish;
  end

  // keeps at most two requests waiting so generation tracks the shadow count closely
  task automatic queue_request(input cmd_e c, input logic [31:0] v, input int unsigned l,
                               input int unsigned p, input int unsigned w);
    pack_req_t r;
    r.cmd   = c;
    r.value = v;
    r.len   = 6'(l);
    r.pos   = 16'(p);
    r.widx  = 10'(w);
    while (pend_q.size() >= 2) @(posedge clk_i);
    pend_q.push_back(r);
  endtask

  // waits until every request is taken and answered, then lets the pipe go quiet
  task automatic settle();
    while (pend_q.size() != 0 || in_valid_i || due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [15:0] bits);
    @(negedge clk_i);
    cfg_wen_i   = 1'b1;
    cfg_wdata_i = bits;
    shadow_cap  = bits;
    @(negedge clk_i);
    cfg_wen_i = 1'b0;
    @(posedge clk_i);
  endtask

  // mostly well-formed traffic: appends, pokes inside the count, modest truncates, clears,
  // reads of fully written words; a share of out-of-range pokes and truncates
  task automatic run_random(input int unsigned n);
    cmd_e        c;
    logic [31:0] v;
    int unsigned l;
    int unsigned p;
    int unsigned w;
    int unsigned roll;
    int unsigned k;
    int unsigned room;
    for (int i = 0; i < n; i++) begin
      c    = CMD_CLEAR;
      v    = $urandom;
      p    = $urandom_range(0, STORE_BITS);
      w    = $urandom_range(0, STORE_WORDS - 1);
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, 9);
      l    = (k == 0) ? 0 : (k == 1) ? 32 : $urandom_range(1, 31);
      if (roll < 40) begin
        c = CMD_APPEND;
      end else if (roll < 58) begin
        c = CMD_POKE;
        if (shadow_count > 0 && $urandom_range(0, 99) < 85) begin
          room = (shadow_count < 32) ? shadow_count : 32;
          l = $urandom_range(0, room);
          p = $urandom_range(0, shadow_count - l);
        end
      end else if (roll < 70) begin
        c = CMD_TRUNC;
        if ($urandom_range(0, 99) < 80) begin
          room = (shadow_count < 64) ? shadow_count : 64;
          p = shadow_count - $urandom_range(0, room);
        end else begin
          p = $urandom_range(shadow_count, STORE_BITS);
        end
      end else if (roll < 92) begin
        if (full_words.size() != 0) begin
          c = CMD_READ;
          w = full_words[$urandom_range(0, full_words.size() - 1)];
        end else begin
          c = CMD_APPEND;
        end
      end
      queue_request(c, v, l, p, w);
    end
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_wen_i      = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_APPEND;
    field_value_i  = '0;
    field_length_i = '0;
    bit_position_i = '0;
    word_index_i   = '0;
    out_ready_i    = 1'b0;
    send_gap_pct   = 18;
    take_gap_pct   = 86;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    set_capacity(16'd32768);
    // fill four words: empty field, all ones, zeros, single bit, boundary split,
    // and a value with a set bit above its length
    queue_request(CMD_APPEND, 32'h0000_0000, 0, 0, 0);
    queue_request(CMD_APPEND, 32'hFFFF_FFFF, 32, 0, 0);
    queue_request(CMD_APPEND, 32'h0000_0000, 32, 0, 0);
    queue_request(CMD_APPEND, 32'h0000_0001, 1, 0, 0);
    queue_request(CMD_APPEND, 32'hA5A5_5A5A, 32, 0, 0);
    queue_request(CMD_APPEND, 32'hFFFF_FFFF, 31, 0, 0);
    for (int i = 0; i < 4; i++) queue_request(CMD_READ, 32'h0, 0, 0, i);
    // poke across the word 1 / word 2 boundary
    queue_request(CMD_POKE, 32'hFFFF_FF3C, 8, 60, 0);
    queue_request(CMD_READ, 32'h0, 0, 0, 1);
    queue_request(CMD_READ, 32'h0, 0, 0, 2);
    // poke past the count, then an empty poke right at the count
    queue_request(CMD_POKE, 32'hFFFF_FFFF, 4, 125, 0);
    queue_request(CMD_POKE, 32'hFFFF_FFFF, 0, 128, 0);
    // truncate upward is refused, to the count is fine, then downward
    queue_request(CMD_TRUNC, 32'h0, 0, 32768, 0);
    queue_request(CMD_TRUNC, 32'h0, 0, 128, 0);
    queue_request(CMD_TRUNC, 32'h0, 0, 100, 0);
    // bits below the truncated count survive the re-append
    queue_request(CMD_APPEND, 32'h0ABC_DEF1, 28, 0, 0);
    queue_request(CMD_READ, 32'h0, 0, 0, 3);
    queue_request(CMD_POKE, 32'h0, 0, 32768, 1023);
    queue_request(CMD_CLEAR, 32'h0, 0, 0, 0);
    queue_request(CMD_POKE, 32'h1234_5678, 32, 0, 0);
    queue_request(CMD_READ, 32'h0, 0, 0, 0);
    queue_request(CMD_TRUNC, 32'h0, 0, 0, 0);
    settle();

    // zero capacity: only empty fields fit
    set_capacity(16'd0);
    queue_request(CMD_APPEND, 32'hFFFF_FFFF, 0, 0, 0);
    queue_request(CMD_APPEND, 32'hFFFF_FFFF, 5, 0, 0);
    queue_request(CMD_POKE, 32'hFFFF_FFFF, 1, 0, 0);
    queue_request(CMD_POKE, 32'hFFFF_FFFF, 0, 0, 0);
    queue_request(CMD_CLEAR, 32'h0, 0, 0, 0);
    settle();

    // small store, slow receiver: overflow is common
    set_capacity(16'd256);
    run_random(260);
    settle();

    // full store, slow sender
    send_gap_pct = 86;
    take_gap_pct = 18;
    set_capacity(16'd32768);
    run_random(260);
    settle();

    // no idling; the receiver first holds off long enough to back the packer up
    send_gap_pct = 0;
    take_gap_pct = 0;
    set_capacity(16'd1024);
    hold_request = 1'b1;
    run_random(260);
    settle();

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("** bitfield_stream_packer_top: PASSED **");
    end else begin
      $display("** bitfield_stream_packer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/bsp_pkg.sv
rtl/bsp_store.sv
rtl/bsp_ctrl.sv
rtl/bsp_outreg.sv
rtl/bitfield_stream_packer_top.sv
sim/bitfield_stream_packer_top_test.sv
